// ===== design/uart_rb_pkg.sv =====
`default_nettype none

package uart_rb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = PTR_W + 1;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [7:0]       t_byte;

    typedef enum logic [1:0] {
        ACT_RX    = 2'd0,
        ACT_TXRDY = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    function automatic t_ptr next_pos(input t_ptr p);
        t_ptr q;
        if (p == t_ptr'(RING_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + t_ptr'(1);
        end
        return q;
    endfunction

    function automatic t_byte fill8(input t_ptr w, input t_ptr r);
        logic [FILL_W-1:0]   f;
        logic [FILL_W+7:0]   ext;
        if (w >= r) begin
            f = {1'b0, w} - {1'b0, r};
        end else begin
            f = {1'b0, w} + FILL_W'(RING_DEPTH) - {1'b0, r};
        end
        ext = {8'd0, f};
        return ext[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/uart_rx_tx_ring_buffers.sv =====
// Receive and transmit byte rings between a UART and software.
// Input channel (i_in_valid / o_in_stall) carries one word: an action
// (line byte received, transmitter ready, software read, software write)
// and a data byte. Output channel (o_out_valid / i_out_stall) returns one
// word per input word: the byte sent to the line, the byte read by
// software, the stored flag, the transmit interrupt enable and both fills.
// Each ring holds RING_DEPTH-1 bytes in a synchronous RAM. A result
// appears the cycle after its input is taken (the RAM read register
// holds the popped byte). Throughput: one word per cycle while the
// output is not stalled. When the receiver stalls, the current result
// is held and o_in_stall rises until the result is taken; the stage
// frees in the same cycle.
// Reset clears both rings' positions, the interrupt enable and the output
// valid; RAM contents are not cleared and need no clearing pass.
`default_nettype none

module uart_rx_tx_ring_buffers
    import uart_rb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_line_valid,
    output logic [7:0]      o_line_byte,
    output logic            o_read_valid,
    output logic [7:0]      o_read_byte,
    output logic            o_accepted,
    output logic            o_tx_irq_on,
    output logic [7:0]      o_rx_fill,
    output logic [7:0]      o_tx_fill
);

    t_byte r_rx_mem [RING_DEPTH];
    t_byte r_tx_mem [RING_DEPTH];
    t_byte r_rx_q, r_tx_q;

    t_ptr r_rx_wr, r_rx_rd, r_tx_wr, r_tx_rd;
    t_ptr n_rx_wr, n_rx_rd, n_tx_wr, n_tx_rd;
    logic r_tx_en, n_tx_en;
    logic r_vld, n_vld;
    logic r_line_vld, n_line_vld;
    logic r_read_vld, n_read_vld;
    logic r_acc, n_acc;

    logic    take;
    t_action act;
    logic    rx_full, rx_empty, tx_full, tx_empty;
    logic    rx_push, rx_pop, tx_push, tx_pop;

    assign o_in_stall = r_vld && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;
    assign act        = t_action'(i_action);

    assign rx_empty = (r_rx_wr == r_rx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);
    assign rx_full  = (next_pos(r_rx_wr) == r_rx_rd);
    assign tx_full  = (next_pos(r_tx_wr) == r_tx_rd);

    always_comb begin
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        n_rx_wr    = r_rx_wr;
        n_rx_rd    = r_rx_rd;
        n_tx_wr    = r_tx_wr;
        n_tx_rd    = r_tx_rd;
        n_tx_en    = r_tx_en;
        n_line_vld = r_line_vld;
        n_read_vld = r_read_vld;
        n_acc      = r_acc;
        n_vld      = r_vld && i_out_stall;
        if (take) begin
            n_vld      = 1'b1;
            n_line_vld = 1'b0;
            n_read_vld = 1'b0;
            n_acc      = 1'b0;
            unique case (act)
                ACT_RX: begin
                    rx_push = !rx_full;
                    n_acc   = !rx_full;
                    if (!rx_full) begin
                        n_rx_wr = next_pos(r_rx_wr);
                    end
                end
                ACT_TXRDY: begin
                    tx_pop     = !tx_empty;
                    n_line_vld = !tx_empty;
                    if (!tx_empty) begin
                        n_tx_rd = next_pos(r_tx_rd);
                    end
                    if (tx_empty || (next_pos(r_tx_rd) == r_tx_wr)) begin
                        n_tx_en = 1'b0;
                    end
                end
                ACT_READ: begin
                    rx_pop     = !rx_empty;
                    n_read_vld = !rx_empty;
                    if (!rx_empty) begin
                        n_rx_rd = next_pos(r_rx_rd);
                    end
                end
                ACT_WRITE: begin
                    tx_push = !tx_full;
                    n_acc   = !tx_full;
                    if (!tx_full) begin
                        n_tx_wr = next_pos(r_tx_wr);
                        if (tx_empty) begin
                            n_tx_en = 1'b1;
                        end
                    end
                end
                default: begin
                    n_vld = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr    <= '0;
            r_rx_rd    <= '0;
            r_tx_wr    <= '0;
            r_tx_rd    <= '0;
            r_tx_en    <= 1'b0;
            r_vld      <= 1'b0;
            r_line_vld <= 1'b0;
            r_read_vld <= 1'b0;
            r_acc      <= 1'b0;
        end else begin
            r_rx_wr    <= n_rx_wr;
            r_rx_rd    <= n_rx_rd;
            r_tx_wr    <= n_tx_wr;
            r_tx_rd    <= n_tx_rd;
            r_tx_en    <= n_tx_en;
            r_vld      <= n_vld;
            r_line_vld <= n_line_vld;
            r_read_vld <= n_read_vld;
            r_acc      <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_push) begin
            r_rx_mem[r_rx_wr] <= i_data;
        end
        if (rx_pop) begin
            r_rx_q <= r_rx_mem[r_rx_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_push) begin
            r_tx_mem[r_tx_wr] <= i_data;
        end
        if (tx_pop) begin
            r_tx_q <= r_tx_mem[r_tx_rd];
        end
    end

    assign o_out_valid  = r_vld;
    assign o_line_valid = r_line_vld;
    assign o_line_byte  = r_line_vld ? r_tx_q : 8'd0;
    assign o_read_valid = r_read_vld;
    assign o_read_byte  = r_read_vld ? r_rx_q : 8'd0;
    assign o_accepted   = r_acc;
    assign o_tx_irq_on  = r_tx_en;
    assign o_rx_fill    = fill8(r_rx_wr, r_rx_rd);
    assign o_tx_fill    = fill8(r_tx_wr, r_tx_rd);

    a_txen_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_en == (r_tx_wr != r_tx_rd))
        else $error("tx interrupt enable out of step with transmit ring");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_line_vld, r_read_vld, r_acc}) <= 1)
        else $error("result carries more than one kind of event");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && i_out_stall) |=> (r_vld && $stable(o_read_byte) && $stable(o_line_byte)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/sv/uart_ring_checker.sv =====
`timescale 1ns / 100ps

module uart_ring_checker
    import uart_rb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic       i_line_valid,
    input  wire logic [7:0] i_line_byte,
    input  wire logic       i_read_valid,
    input  wire logic [7:0] i_read_byte,
    input  wire logic       i_accepted,
    input  wire logic       i_tx_irq_on,
    input  wire logic [7:0] i_rx_fill,
    input  wire logic [7:0] i_tx_fill,
    output int              o_errors,
    output int              o_pending,
    output int              o_checked,
    output int              o_rx_drops,
    output int              o_tx_drops
);

    typedef struct packed {
        logic  line_valid;
        t_byte line_byte;
        logic  read_valid;
        t_byte read_byte;
        logic  accepted;
        logic  tx_irq_on;
        t_byte rx_fill;
        t_byte tx_fill;
    } t_ring_word;

    t_byte rx_ring [RING_DEPTH];
    t_byte tx_ring [RING_DEPTH];
    t_ptr  rx_head = '0;
    t_ptr  rx_tail = '0;
    t_ptr  tx_head = '0;
    t_ptr  tx_tail = '0;
    logic  tx_irq  = 1'b0;

    t_ring_word ring_words_due[$];
    int         errors   = 0;
    int         checked  = 0;
    int         rx_drops = 0;
    int         tx_drops = 0;

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        o_checked  = 0;
        o_rx_drops = 0;
        o_tx_drops = 0;
    end

    function automatic t_ptr advance(input t_ptr p);
        return t_ptr'((int'(p) + 1) % RING_DEPTH);
    endfunction

    function automatic t_byte bytes_held(input t_ptr head, input t_ptr tail);
        int n;
        n = (int'(head) + RING_DEPTH - int'(tail)) % RING_DEPTH;
        return t_byte'(n);
    endfunction

    function automatic t_ring_word apply_word(input t_action act, input t_byte d);
        t_ring_word r;
        logic       was_empty;
        r = '0;
        case (act)
            ACT_RX: begin
                if (advance(rx_head) != rx_tail) begin
                    rx_ring[rx_head] = d;
                    rx_head = advance(rx_head);
                    r.accepted = 1'b1;
                end else begin
                    rx_drops++;
                end
            end
            ACT_TXRDY: begin
                if (tx_head != tx_tail) begin
                    r.line_valid = 1'b1;
                    r.line_byte = tx_ring[tx_tail];
                    tx_tail = advance(tx_tail);
                end
                if (tx_head == tx_tail) tx_irq = 1'b0;
            end
            ACT_READ: begin
                if (rx_head != rx_tail) begin
                    r.read_valid = 1'b1;
                    r.read_byte = rx_ring[rx_tail];
                    rx_tail = advance(rx_tail);
                end
            end
            ACT_WRITE: begin
                was_empty = (tx_head == tx_tail);
                if (advance(tx_head) != tx_tail) begin
                    tx_ring[tx_head] = d;
                    tx_head = advance(tx_head);
                    r.accepted = 1'b1;
                end else begin
                    tx_drops++;
                end
                if (was_empty && tx_head != tx_tail) tx_irq = 1'b1;
            end
        endcase
        r.tx_irq_on = tx_irq;
        r.rx_fill = bytes_held(rx_head, rx_tail);
        r.tx_fill = bytes_held(tx_head, tx_tail);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 20) begin
            $display("%0t: word %0d %s: got %0d, want %0d", $realtime, checked, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_ring_word want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                ring_words_due.push_back(apply_word(t_action'(i_action), i_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (ring_words_due.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = ring_words_due.pop_front();
                    check_field("line_valid", int'(i_line_valid), int'(want.line_valid));
                    check_field("line_byte", int'(i_line_byte), int'(want.line_byte));
                    check_field("read_valid", int'(i_read_valid), int'(want.read_valid));
                    check_field("read_byte", int'(i_read_byte), int'(want.read_byte));
                    check_field("accepted", int'(i_accepted), int'(want.accepted));
                    check_field("tx_irq_on", int'(i_tx_irq_on), int'(want.tx_irq_on));
                    check_field("rx_fill", int'(i_rx_fill), int'(want.rx_fill));
                    check_field("tx_fill", int'(i_tx_fill), int'(want.tx_fill));
                end
                checked++;
            end
            o_errors   <= errors;
            o_pending  <= ring_words_due.size();
            o_checked  <= checked;
            o_rx_drops <= rx_drops;
            o_tx_drops <= tx_drops;
        end
    end

endmodule

// ===== tb/sv/uart_rx_tx_ring_buffers_tb.sv =====
`timescale 1ns / 100ps

module uart_rx_tx_ring_buffers_tb;
    import uart_rb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} t_mix_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_action;
    logic [7:0] i_data;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_line_valid;
    logic [7:0] o_line_byte;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic       o_accepted;
    logic       o_tx_irq_on;
    logic [7:0] o_rx_fill;
    logic [7:0] o_tx_fill;

    int errors;
    int pending;
    int checked;
    int rx_drops;
    int tx_drops;
    int cycles       = 0;
    int held_off     = 0;
    int sent         = 0;
    bit gaps_on      = 1'b1;

    uart_rx_tx_ring_buffers dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_data       (i_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_valid (o_line_valid),
        .o_line_byte  (o_line_byte),
        .o_read_valid (o_read_valid),
        .o_read_byte  (o_read_byte),
        .o_accepted   (o_accepted),
        .o_tx_irq_on  (o_tx_irq_on),
        .o_rx_fill    (o_rx_fill),
        .o_tx_fill    (o_tx_fill)
    );

    uart_ring_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_data       (i_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_line_valid (o_line_valid),
        .i_line_byte  (o_line_byte),
        .i_read_valid (o_read_valid),
        .i_read_byte  (o_read_byte),
        .i_accepted   (o_accepted),
        .i_tx_irq_on  (o_tx_irq_on),
        .i_rx_fill    (o_rx_fill),
        .i_tx_fill    (o_tx_fill),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rx_drops   (rx_drops),
        .o_tx_drops   (tx_drops)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_stall) held_off++;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_word(input t_action act, input t_byte d);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 1) == 1) begin
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_data     <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        if (sent % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
    endtask

    function automatic t_action pick_action(input t_mix_mode m);
        int roll;
        roll = $urandom_range(0, 99);
        case (m)
            MODE_FILL: begin
                if (roll < 49) return ACT_RX;
                if (roll < 98) return ACT_WRITE;
            end
            MODE_DRAIN: begin
                if (roll < 47) return ACT_READ;
                if (roll < 94) return ACT_TXRDY;
            end
            default: begin
            end
        endcase
        return t_action'($urandom_range(0, 3));
    endfunction

    task automatic run_episode(input t_mix_mode m, input int count);
        repeat (count) send_word(pick_action(m), t_byte'($urandom_range(0, 255)));
    endtask

    initial begin
        int iter;
        int len;
        iter = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            iter++;
            if (iter == 30) begin
                // hold off long enough for the input side to back up
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else if (iter % 16 == 0 && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b0;
                repeat (100) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_RX;
        i_data     <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty rings, interrupt enable rise and fall, data extremes
        send_word(ACT_READ, 8'hFF);
        send_word(ACT_TXRDY, 8'hFF);
        send_word(ACT_WRITE, 8'h00);
        send_word(ACT_WRITE, 8'hFF);
        send_word(ACT_TXRDY, 8'h00);
        send_word(ACT_TXRDY, 8'h00);
        send_word(ACT_TXRDY, 8'h00);
        send_word(ACT_RX, 8'h00);
        send_word(ACT_RX, 8'hFF);
        send_word(ACT_RX, 8'hA5);
        send_word(ACT_RX, 8'h5A);
        send_word(ACT_READ, 8'h00);
        send_word(ACT_READ, 8'hFF);
        send_word(ACT_READ, 8'h00);
        send_word(ACT_READ, 8'h00);
        send_word(ACT_READ, 8'h00);
        send_word(ACT_WRITE, 8'h55);
        send_word(ACT_WRITE, 8'hAA);
        send_word(ACT_TXRDY, 8'hFF);
        send_word(ACT_WRITE, 8'h01);
        send_word(ACT_TXRDY, 8'h80);
        send_word(ACT_TXRDY, 8'h7F);
        send_word(ACT_TXRDY, 8'h00);

        run_episode(MODE_MIX, 100);
        run_episode(MODE_FILL, 560);
        run_episode(MODE_DRAIN, 300);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run checked %0d result words; %0d receive and %0d transmit bytes dropped full.",
                 checked, rx_drops, tx_drops);
        $display("Input was held off by the block for %0d cycles.", held_off);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
